### sv/grw_pkg.sv
`timescale 1ns / 1ps

package grw_pkg;

    // Width of each result field on the port
    localparam int OUT_W = 32;
    // Width of each input field on the port
    localparam int IN_W = 32;

    typedef struct packed {
        logic neg_a;
        logic neg_b;
        logic zero;
    } grw_flags_t;

endpackage

### sv/grw_sqrt.sv
`timescale 1ns / 1ps

// Floored square root, one result bit per stage.
module grw_sqrt #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [2*DATA_WIDTH-1:0]   in_sum,
    input  logic [DATA_WIDTH-1:0]     in_mag_a,
    input  logic [DATA_WIDTH-1:0]     in_mag_b,
    input  grw_pkg::grw_flags_t       in_flags,
    output logic                      out_valid,
    output logic [DATA_WIDTH-1:0]     out_root,
    output logic [DATA_WIDTH-1:0]     out_mag_a,
    output logic [DATA_WIDTH-1:0]     out_mag_b,
    output grw_pkg::grw_flags_t       out_flags
);

    localparam int RW = 2 * DATA_WIDTH;

    logic                  valid_reg [DATA_WIDTH];
    logic [RW-1:0]         rem_reg   [DATA_WIDTH];
    logic [DATA_WIDTH-1:0] root_reg  [DATA_WIDTH];
    logic [DATA_WIDTH-1:0] ma_reg    [DATA_WIDTH];
    logic [DATA_WIDTH-1:0] mb_reg    [DATA_WIDTH];
    grw_pkg::grw_flags_t   flags_reg [DATA_WIDTH];

    for (genvar s = 0; s < DATA_WIDTH; s++) begin : g_stage
        localparam int BP = DATA_WIDTH - 1 - s;

        logic                  valid_cur;
        logic [RW-1:0]         rem_cur;
        logic [DATA_WIDTH-1:0] root_cur;
        logic [DATA_WIDTH-1:0] ma_cur;
        logic [DATA_WIDTH-1:0] mb_cur;
        grw_pkg::grw_flags_t   flags_cur;
        logic [RW:0]           trial;
        logic                  take;
        logic [RW-1:0]         rem_next;
        logic [DATA_WIDTH-1:0] root_next;

        if (s == 0) begin : g_first
            assign valid_cur = in_valid;
            assign rem_cur   = in_sum;
            assign root_cur  = '0;
            assign ma_cur    = in_mag_a;
            assign mb_cur    = in_mag_b;
            assign flags_cur = in_flags;
        end else begin : g_next
            assign valid_cur = valid_reg[s-1];
            assign rem_cur   = rem_reg[s-1];
            assign root_cur  = root_reg[s-1];
            assign ma_cur    = ma_reg[s-1];
            assign mb_cur    = mb_reg[s-1];
            assign flags_cur = flags_reg[s-1];
        end

        // remainder holds n - root^2; test (root + 2^BP)^2
        assign trial = ({{(DATA_WIDTH+1){1'b0}}, root_cur} << (BP + 1))
                     + ((RW+1)'(1) << (2 * BP));
        assign take      = {1'b0, rem_cur} >= trial;
        assign rem_next  = take ? rem_cur - trial[RW-1:0] : rem_cur;
        assign root_next = take ? (root_cur | (DATA_WIDTH'(1) << BP)) : root_cur;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= valid_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]   <= rem_next;
                root_reg[s]  <= root_next;
                ma_reg[s]    <= ma_cur;
                mb_reg[s]    <= mb_cur;
                flags_reg[s] <= flags_cur;
            end
        end
    end

    assign out_valid = valid_reg[DATA_WIDTH-1];
    assign out_root  = root_reg[DATA_WIDTH-1];
    assign out_mag_a = ma_reg[DATA_WIDTH-1];
    assign out_mag_b = mb_reg[DATA_WIDTH-1];
    assign out_flags = flags_reg[DATA_WIDTH-1];

endmodule

### sv/grw_div.sv
`timescale 1ns / 1ps

// Two restoring dividers sharing a divisor, one quotient bit per stage.
module grw_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 30
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [DATA_WIDTH-1:0]   in_num_a,
    input  logic [DATA_WIDTH-1:0]   in_num_b,
    input  logic [DATA_WIDTH-1:0]   in_den,
    input  grw_pkg::grw_flags_t     in_flags,
    output logic                    out_valid,
    output logic [FRAC_BITS:0]      out_quo_a,
    output logic [FRAC_BITS:0]      out_quo_b,
    output grw_pkg::grw_flags_t     out_flags
);

    localparam int NS = FRAC_BITS + 1;
    localparam int RW = DATA_WIDTH + FRAC_BITS + 1;

    logic                  valid_reg [NS];
    logic [RW-1:0]         rem_a_reg [NS];
    logic [RW-1:0]         rem_b_reg [NS];
    logic [FRAC_BITS:0]    qa_reg    [NS];
    logic [FRAC_BITS:0]    qb_reg    [NS];
    logic [DATA_WIDTH-1:0] den_reg   [NS];
    grw_pkg::grw_flags_t   flags_reg [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        localparam int J = FRAC_BITS - s;

        logic                  valid_cur;
        logic [RW-1:0]         rem_a_cur;
        logic [RW-1:0]         rem_b_cur;
        logic [FRAC_BITS:0]    qa_cur;
        logic [FRAC_BITS:0]    qb_cur;
        logic [DATA_WIDTH-1:0] den_cur;
        grw_pkg::grw_flags_t   flags_cur;
        logic [RW-1:0]         dsh;
        logic                  take_a;
        logic                  take_b;
        logic [RW-1:0]         rem_a_next;
        logic [RW-1:0]         rem_b_next;
        logic [FRAC_BITS:0]    qa_next;
        logic [FRAC_BITS:0]    qb_next;

        if (s == 0) begin : g_first
            assign valid_cur = in_valid;
            assign rem_a_cur = RW'(in_num_a) << FRAC_BITS;
            assign rem_b_cur = RW'(in_num_b) << FRAC_BITS;
            assign qa_cur    = '0;
            assign qb_cur    = '0;
            assign den_cur   = in_den;
            assign flags_cur = in_flags;
        end else begin : g_next
            assign valid_cur = valid_reg[s-1];
            assign rem_a_cur = rem_a_reg[s-1];
            assign rem_b_cur = rem_b_reg[s-1];
            assign qa_cur    = qa_reg[s-1];
            assign qb_cur    = qb_reg[s-1];
            assign den_cur   = den_reg[s-1];
            assign flags_cur = flags_reg[s-1];
        end

        assign dsh        = RW'(den_cur) << J;
        assign take_a     = rem_a_cur >= dsh;
        assign take_b     = rem_b_cur >= dsh;
        assign rem_a_next = take_a ? rem_a_cur - dsh : rem_a_cur;
        assign rem_b_next = take_b ? rem_b_cur - dsh : rem_b_cur;
        assign qa_next    = take_a ? (qa_cur | ((FRAC_BITS+1)'(1) << J)) : qa_cur;
        assign qb_next    = take_b ? (qb_cur | ((FRAC_BITS+1)'(1) << J)) : qb_cur;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= valid_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_a_reg[s] <= rem_a_next;
                rem_b_reg[s] <= rem_b_next;
                qa_reg[s]    <= qa_next;
                qb_reg[s]    <= qb_next;
                den_reg[s]   <= den_cur;
                flags_reg[s] <= flags_cur;
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_quo_a = qa_reg[NS-1];
    assign out_quo_b = qb_reg[NS-1];
    assign out_flags = flags_reg[NS-1];

endmodule

### sv/givens_rotation_weights.sv
`timescale 1ns / 1ps

// Givens rotation weights: for each beat (a, b) returns cosine = a/r and
// sine = b/r in signed Q2.30 (FRAC_BITS fraction bits), r = floor(sqrt(a^2+b^2)),
// quotients truncated toward zero; a zero vector gives cosine 1.0, sine 0.
// Fully pipelined: one beat per cycle while m_tready does not stall the output; the
// pipeline depth is set by the bit-per-stage square root and the bit-per-stage
// dividers. A stall on m_tready holds the whole pipeline.
module givens_rotation_weights #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // a [31:0], b [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // cosine [31:0], sine [63:32]
);

    localparam int OW = grw_pkg::OUT_W;
    localparam int IW = grw_pkg::IN_W;

    logic en;

    // stage 0: magnitudes
    logic [DATA_WIDTH-1:0] a_raw, b_raw, ma_next, mb_next;
    grw_pkg::grw_flags_t   f0_next;
    logic                  v0_reg;
    logic [DATA_WIDTH-1:0] ma0_reg, mb0_reg;
    grw_pkg::grw_flags_t   f0_reg;

    // stage 1: squares, stage 2: sum
    logic                    v1_reg, v2_reg;
    logic [2*DATA_WIDTH-1:0] sqa_reg, sqb_reg, sum_reg;
    logic [DATA_WIDTH-1:0]   ma1_reg, mb1_reg, ma2_reg, mb2_reg;
    grw_pkg::grw_flags_t     f1_reg, f2_reg;

    // square root outputs
    logic                  sq_valid;
    logic [DATA_WIDTH-1:0] sq_root, sq_ma, sq_mb, den;
    grw_pkg::grw_flags_t   sq_flags;

    // divider outputs
    logic                 dv_valid;
    logic [FRAC_BITS:0]   quo_a, quo_b;
    grw_pkg::grw_flags_t  dv_flags;

    logic                 out_valid_reg;
    logic [OW-1:0]        cos_reg, sin_reg, cos_next, sin_next;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    assign a_raw = s_tdata[DATA_WIDTH-1:0];
    assign b_raw = s_tdata[IW+DATA_WIDTH-1:IW];

    // negation of the most negative value lands on 2^(DW-1), read unsigned
    assign ma_next         = a_raw[DATA_WIDTH-1] ? (~a_raw + 1'b1) : a_raw;
    assign mb_next         = b_raw[DATA_WIDTH-1] ? (~b_raw + 1'b1) : b_raw;
    assign f0_next.neg_a   = a_raw[DATA_WIDTH-1];
    assign f0_next.neg_b   = b_raw[DATA_WIDTH-1];
    assign f0_next.zero    = (a_raw == '0) && (b_raw == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma0_reg <= ma_next;
            mb0_reg <= mb_next;
            f0_reg  <= f0_next;
            sqa_reg <= (2*DATA_WIDTH)'(ma0_reg) * (2*DATA_WIDTH)'(ma0_reg);
            sqb_reg <= (2*DATA_WIDTH)'(mb0_reg) * (2*DATA_WIDTH)'(mb0_reg);
            ma1_reg <= ma0_reg;
            mb1_reg <= mb0_reg;
            f1_reg  <= f0_reg;
            sum_reg <= sqa_reg + sqb_reg;
            ma2_reg <= ma1_reg;
            mb2_reg <= mb1_reg;
            f2_reg  <= f1_reg;
        end
    end

    grw_sqrt #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .in_sum    (sum_reg),
        .in_mag_a  (ma2_reg),
        .in_mag_b  (mb2_reg),
        .in_flags  (f2_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_mag_a (sq_ma),
        .out_mag_b (sq_mb),
        .out_flags (sq_flags)
    );

    // root is zero only for the zero vector; keep the divider defined
    assign den = (sq_root == '0) ? DATA_WIDTH'(1) : sq_root;

    grw_div #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_num_a  (sq_ma),
        .in_num_b  (sq_mb),
        .in_den    (den),
        .in_flags  (sq_flags),
        .out_valid (dv_valid),
        .out_quo_a (quo_a),
        .out_quo_b (quo_b),
        .out_flags (dv_flags)
    );

    always_comb begin
        if (dv_flags.zero) begin
            cos_next = OW'(1) << FRAC_BITS;
            sin_next = '0;
        end else begin
            cos_next = dv_flags.neg_a ? (OW'(0) - OW'(quo_a)) : OW'(quo_a);
            sin_next = dv_flags.neg_b ? (OW'(0) - OW'(quo_b)) : OW'(quo_b);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {sin_reg, cos_reg};

`ifndef NO_ASSERTIONS
    // the input side only stalls behind a held result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled without a pending result");

    // root is zero exactly for the zero vector
    assert property (@(posedge aclk) disable iff (!aresetn)
        sq_valid |-> ((sq_root == '0) == sq_flags.zero))
        else $error("square root disagrees with zero flag");

    // weights never exceed 1.0 in magnitude
    assert property (@(posedge aclk) disable iff (!aresetn)
        dv_valid |-> (quo_a <= ((FRAC_BITS+1)'(1) << FRAC_BITS)
                   && quo_b <= ((FRAC_BITS+1)'(1) << FRAC_BITS)))
        else $error("quotient above unity");
`endif

endmodule

### dv/givens_rotation_weights_test.sv
`timescale 1ns / 1ps

module givens_rotation_weights_test;

    localparam int FRAC = 30;
    localparam int PIPE_LAT = 67;
    localparam int N_RAND = 900;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [31:0] sine;
        logic signed [31:0] cosine;
    } weights_t;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        bit          known;
        weights_t    w;
    } vec_row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;

    weights_t    weights_q[$];
    int          n_err = 0;
    longint      cycles = 0;
    bit          hold_sink = 0;
    bit          src_done = 0;

    givens_rotation_weights dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt >>= 2;
        while (bt != 0) begin
            if (n >= res + bt) begin
                n -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic weights_t rotation_weights(logic [31:0] a, logic [31:0] b);
        logic [63:0] ma, mb, r, qc, qs;
        weights_t w;
        ma = a[31] ? 64'(-$signed({32'hffffffff, a})) : {32'd0, a};
        mb = b[31] ? 64'(-$signed({32'hffffffff, b})) : {32'd0, b};
        if (ma == 0 && mb == 0) begin
            w.cosine = 32'sd1 << FRAC;
            w.sine = 0;
            return w;
        end
        r = int_sqrt(ma * ma + mb * mb);
        if (r == 0) r = 1;
        qc = (ma << FRAC) / r;
        qs = (mb << FRAC) / r;
        w.cosine = a[31] ? -qc[31:0] : qc[31:0];
        w.sine = b[31] ? -qs[31:0] : qs[31:0];
        return w;
    endfunction

    // idle gap after a beat; with no gap the next beat follows back to back
    task automatic src_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) g = 0;
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(negedge aclk);
        end
    endtask

    task automatic send_vec(logic [31:0] a, logic [31:0] b, bit known, weights_t w);
        s_tvalid <= 1;
        s_tdata <= {b, a};
        do @(posedge aclk); while (!s_tready);
        weights_q.push_back(known ? w : rotation_weights(a, b));
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3) - 1;
            1: return 32'h80000000 + $urandom_range(0, 2);
            2: return 32'h7fffffff - $urandom_range(0, 2);
            3: return $urandom_range(0, 1000) - 500;
            default: return $urandom;
        endcase
    endfunction

    // directed vectors; results typed in only for the obvious ones
    vec_row_t vec_rows[] = '{
        '{32'd0, 32'd0, 1, '{32'sd0, 32'sd1073741824}},
        '{32'd5, 32'd0, 1, '{32'sd0, 32'sd1073741824}},
        '{-32'd5, 32'd0, 1, '{32'sd0, -32'sd1073741824}},
        '{32'd0, 32'd7, 1, '{32'sd1073741824, 32'sd0}},
        '{32'd0, -32'd7, 1, '{-32'sd1073741824, 32'sd0}},
        '{32'd3, 32'd4, 0, '0},
        '{-32'd3, 32'd4, 0, '0},
        '{32'd3, -32'd4, 0, '0},
        '{32'h7fffffff, 32'h7fffffff, 0, '0},
        '{32'h80000000, 32'h80000000, 0, '0},
        '{32'h80000000, 32'd0, 1, '{32'sd0, -32'sd1073741824}},
        '{32'd0, 32'h80000000, 1, '{-32'sd1073741824, 32'sd0}},
        '{32'h7fffffff, 32'h80000000, 0, '0},
        '{32'h80000000, 32'h7fffffff, 0, '0},
        '{32'd1, 32'd1, 0, '0},
        '{32'hffffffff, 32'hffffffff, 0, '0},
        '{32'h7fffffff, 32'd1, 0, '0},
        '{32'd1, 32'h7fffffff, 0, '0},
        '{32'haaaaaaaa, 32'h55555555, 0, '0},
        '{32'h55555555, 32'haaaaaaaa, 0, '0}
    };

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        foreach (vec_rows[i]) begin
            send_vec(vec_rows[i].a, vec_rows[i].b, vec_rows[i].known, vec_rows[i].w);
            src_gap();
        end
        // sender pause until the pipe drains
        s_tvalid <= 0;
        while (weights_q.size() != 0) @(negedge aclk);
        for (int i = 0; i < N_RAND; i++) begin
            if (i == 300) hold_sink = 1;
            send_vec(rand_comp(), rand_comp(), 0, '0);
            if (i < 300 || i > 500) src_gap();
        end
        s_tvalid <= 0;
        src_done = 1;
    end

    // sink: random backpressure, one long hold-off while the source keeps going
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                m_tready <= 0;
                repeat (300) @(negedge aclk);
                hold_sink = 0;
            end
            if ($urandom_range(0, 2) == 0) begin
                m_tready <= 1;
            end else begin
                g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
                if (g == 0) begin
                    m_tready <= 1;
                end else begin
                    m_tready <= 0;
                    repeat (g) @(negedge aclk);
                    m_tready <= 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        weights_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (weights_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected beat %h", m_tdata);
            end else begin
                want = weights_q.pop_front();
                if (got.cosine !== want.cosine || got.sine !== want.sine) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: cos %0d/%0d sin %0d/%0d (exp/got)",
                                 want.cosine, got.cosine, want.sine, got.sine);
                end
            end
        end
    end

    initial begin
        wait (src_done);
        while (weights_q.size() != 0 && cycles < CYCLE_LIMIT) @(posedge aclk);
        repeat (2 * PIPE_LAT) @(posedge aclk);
        if (cycles < CYCLE_LIMIT) begin
            if (n_err == 0 && weights_q.size() == 0) begin
                $display("Verification passed");
            end else begin
                $display("Verification failed");
            end
            $finish;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end
endmodule
